/* sv/htfd_pkg.sv */
// ----------------------------------------------------------------------------
// htfd_pkg: shared constants and types
// Widths, scaling constants and the frame info bundle of the frame decoder.
// ----------------------------------------------------------------------------
package htfd_pkg;

    localparam int WINDOW_DEPTH = 3;
    localparam int HDR_BYTES    = 6;     // status + five code bytes; the seventh byte is not stored
    localparam int POS_W        = 3;
    localparam int BYTE_W       = 8;
    localparam int CODE_BITS    = 20;
    localparam int CNT_W        = $clog2(CODE_BITS);

    localparam int TVAL_W       = 15;
    localparam int HVAL_W       = 14;
    localparam int TEMP_SPAN    = 20000;
    localparam int HUMID_SPAN   = 10000;
    localparam int TEMP_OFFSET  = 5000;

    localparam int FILL_W       = $clog2(WINDOW_DEPTH + 1);
    localparam int TSUM_W       = TVAL_W + $clog2(WINDOW_DEPTH) + 1;
    localparam int HSUM_W       = HVAL_W + $clog2(WINDOW_DEPTH) + 1;
    localparam int DIV_W        = TSUM_W;
    localparam int DCNT_W       = $clog2(DIV_W);

    localparam logic [BYTE_W-1:0] NIB_LO = 8'h0F;
    localparam logic [BYTE_W-1:0] NIB_HI = 8'hF0;

    typedef struct packed {
        logic                    last;     // seventh byte accepted this cycle
        logic [BYTE_W-1:0]       status;
        logic [CODE_BITS-1:0]    raw_t;
        logic [CODE_BITS-1:0]    raw_h;
    } t_frame_info;

endpackage

/* sv/htfd_ifs.sv */
// ----------------------------------------------------------------------------
// htfd_ifs: stream channels
// Valid/ready channels for received bytes and for averaged results.
// ----------------------------------------------------------------------------
interface htfd_in_if import htfd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;
    logic              frame_start;

    modport source (output valid, output rx_byte, output frame_start, input ready);
    modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface htfd_out_if import htfd_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [TVAL_W-1:0] temperature_avg;
    logic [HVAL_W-1:0]       humidity_avg;
    logic [1:0]              samples_in_window;
    logic [CODE_BITS-1:0]    raw_temp_code;
    logic [CODE_BITS-1:0]    raw_humid_code;
    logic [BYTE_W-1:0]       sensor_status;

    modport source (output valid, output temperature_avg, output humidity_avg,
                    output samples_in_window, output raw_temp_code,
                    output raw_humid_code, output sensor_status, input ready);
    modport sink   (input valid, input temperature_avg, input humidity_avg,
                    input samples_in_window, input raw_temp_code,
                    input raw_humid_code, input sensor_status, output ready);
endinterface

/* sv/htfd_frame_asm.sv */
// ----------------------------------------------------------------------------
// htfd_frame_asm: frame byte capture
// Tracks the byte position and holds the status and code bytes of a frame.
// ----------------------------------------------------------------------------
module htfd_frame_asm import htfd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [BYTE_W-1:0] i_rx_byte,
    input  logic              i_frame_start,
    output t_frame_info       o_frame
);

    logic [POS_W-1:0]  r_pos;
    logic [POS_W-1:0]  n_pos;
    logic [POS_W-1:0]  w_pos;
    logic              w_store;
    logic [BYTE_W-1:0] r_bytes [HDR_BYTES];

    always_comb begin
        w_pos   = i_frame_start ? '0 : r_pos;
        w_store = (w_pos < POS_W'(HDR_BYTES));
        n_pos   = r_pos;
        if (i_accept) begin
            n_pos = w_store ? w_pos + 1'b1 : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && w_store) begin
            r_bytes[w_pos] <= i_rx_byte;
        end
    end

    // humidity = b1:b2:b3[7:4], temperature = b3[3:0]:b4:b5
    always_comb begin
        o_frame.last   = i_accept && !w_store;
        o_frame.status = r_bytes[0];
        o_frame.raw_h  = {r_bytes[1], r_bytes[2], 4'((r_bytes[3] & NIB_HI) >> 4)};
        o_frame.raw_t  = {4'(r_bytes[3] & NIB_LO), r_bytes[4], r_bytes[5]};
    end

endmodule

/* sv/htfd_scale.sv */
// ----------------------------------------------------------------------------
// htfd_scale: bit-serial scaling
// floor(raw * span / 2^20) for both codes, one code bit per cycle, LSB first.
// ----------------------------------------------------------------------------
module htfd_scale import htfd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  logic [CODE_BITS-1:0] i_raw_t,
    input  logic [CODE_BITS-1:0] i_raw_h,
    output logic [TVAL_W-1:0]    o_temp_code,
    output logic [HVAL_W-1:0]    o_humid_code,
    output logic                 o_done
);

    logic [CODE_BITS-1:0] r_raw_t;
    logic [CODE_BITS-1:0] r_raw_h;
    logic [TVAL_W-1:0]    r_acc_t;
    logic [HVAL_W-1:0]    r_acc_h;
    logic [TVAL_W:0]      w_sum_t;
    logic [HVAL_W:0]      w_sum_h;
    logic [CNT_W-1:0]     r_step;
    logic                 r_busy;
    logic                 r_done;

    // add-then-halve; the flooring of each halving composes exactly
    always_comb begin
        w_sum_t = {1'b0, r_acc_t} + (r_raw_t[0] ? (TVAL_W+1)'(TEMP_SPAN) : '0);
        w_sum_h = {1'b0, r_acc_h} + (r_raw_h[0] ? (HVAL_W+1)'(HUMID_SPAN) : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_load) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == CNT_W'(CODE_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_raw_t <= i_raw_t;
            r_raw_h <= i_raw_h;
            r_acc_t <= '0;
            r_acc_h <= '0;
        end else if (r_busy) begin
            r_raw_t <= r_raw_t >> 1;
            r_raw_h <= r_raw_h >> 1;
            r_acc_t <= w_sum_t[TVAL_W:1];
            r_acc_h <= w_sum_h[HVAL_W:1];
        end
    end

    assign o_temp_code  = r_acc_t;
    assign o_humid_code = r_acc_h;
    assign o_done       = r_done;

endmodule

/* sv/htfd_avg_div.sv */
// ----------------------------------------------------------------------------
// htfd_avg_div: serial averaging divider
// Restoring division of both window sums by the fill count, one bit a cycle.
// ----------------------------------------------------------------------------
module htfd_avg_div import htfd_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_load,
    input  logic signed [TSUM_W-1:0] i_sum_t,
    input  logic [HSUM_W-1:0]        i_sum_h,
    input  logic [FILL_W-1:0]        i_cnt,
    output logic signed [TVAL_W-1:0] o_avg_t,
    output logic [HVAL_W-1:0]        o_avg_h,
    output logic                     o_done
);

    logic [DIV_W-1:0]  r_q_t;
    logic [DIV_W-1:0]  r_q_h;
    logic [FILL_W-1:0] r_rem_t;
    logic [FILL_W-1:0] r_rem_h;
    logic [FILL_W-1:0] r_div;
    logic              r_neg;
    logic [DCNT_W-1:0] r_step;
    logic              r_busy;
    logic              r_done;
    logic [DIV_W-1:0]  w_mag;
    logic [FILL_W:0]   w_try_t;
    logic [FILL_W:0]   w_try_h;
    logic              w_ge_t;
    logic              w_ge_h;
    logic [DIV_W-1:0]  w_signed_q;

    // truncation toward zero: divide the magnitude, restore the sign afterwards
    always_comb begin
        w_mag   = i_sum_t[TSUM_W-1] ? DIV_W'(~i_sum_t + 1'b1) : DIV_W'(i_sum_t);
        w_try_t = {r_rem_t, r_q_t[DIV_W-1]};
        w_try_h = {r_rem_h, r_q_h[DIV_W-1]};
        w_ge_t  = (w_try_t >= {1'b0, r_div});
        w_ge_h  = (w_try_h >= {1'b0, r_div});
        w_signed_q = r_neg ? (~r_q_t + 1'b1) : r_q_t;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_load) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == DCNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_q_t   <= w_mag;
            r_q_h   <= DIV_W'(i_sum_h);
            r_rem_t <= '0;
            r_rem_h <= '0;
            r_div   <= i_cnt;
            r_neg   <= i_sum_t[TSUM_W-1];
        end else if (r_busy) begin
            r_q_t   <= {r_q_t[DIV_W-2:0], w_ge_t};
            r_q_h   <= {r_q_h[DIV_W-2:0], w_ge_h};
            r_rem_t <= FILL_W'(w_ge_t ? w_try_t - {1'b0, r_div} : w_try_t);
            r_rem_h <= FILL_W'(w_ge_h ? w_try_h - {1'b0, r_div} : w_try_h);
        end
    end

    assign o_avg_t = signed'(w_signed_q[TVAL_W-1:0]);
    assign o_avg_h = r_q_h[HVAL_W-1:0];
    assign o_done  = r_done;

endmodule

/* sv/humidity_temp_frame_decode_average_core.sv */
// Bytes 1 to 6 of a frame are stored as they come and produce no item.
// The seventh byte starts serial scaling, then a window update, the divider
// load, serial division, the step into the output state and the output
// register load, after which its item is valid.
// No byte is taken during that work; the next one goes in once the core is
// idle again, later while the previous item still waits unread.
// Synchronous active-low reset clears position, window, fill and handshakes.
// ----------------------------------------------------------------------------
// humidity_temp_frame_decode_average_core: sensor frame decoder and averager
// Decodes seven-byte humidity/temperature frames and averages up to the last three.
// ----------------------------------------------------------------------------
module humidity_temp_frame_decode_average_core import htfd_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    htfd_in_if.sink       i_in,
    htfd_out_if.source    o_out
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCALE = 3'd1;
    localparam logic [2:0] S_LOAD  = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0]               r_state;
    logic [2:0]               n_state;
    logic                     w_in_accept;
    logic                     w_out_free;
    logic                     w_out_load;
    t_frame_info              w_frame;
    logic [TVAL_W-1:0]        w_temp_code;
    logic [HVAL_W-1:0]        w_humid_code;
    logic                     w_scale_done;
    logic signed [TVAL_W-1:0] w_tval;
    logic signed [TVAL_W-1:0] r_twin [WINDOW_DEPTH];
    logic [HVAL_W-1:0]        r_hwin [WINDOW_DEPTH];
    logic [FILL_W-1:0]        r_fill;
    logic signed [TSUM_W-1:0] w_sum_t;
    logic [HSUM_W-1:0]        w_sum_h;
    logic signed [TVAL_W-1:0] w_avg_t;
    logic [HVAL_W-1:0]        w_avg_h;
    logic                     w_div_done;

    logic                     r_out_valid;
    logic signed [TVAL_W-1:0] r_out_temp;
    logic [HVAL_W-1:0]        r_out_humid;
    logic [1:0]               r_out_samples;
    logic [CODE_BITS-1:0]     r_out_raw_t;
    logic [CODE_BITS-1:0]     r_out_raw_h;
    logic [BYTE_W-1:0]        r_out_status;

    assign i_in.ready  = (r_state == S_IDLE);
    assign w_in_accept = i_in.valid && i_in.ready;
    assign w_out_free  = !r_out_valid || o_out.ready;
    assign w_out_load  = (r_state == S_OUT) && w_out_free;

    htfd_frame_asm u_frame (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_in_accept),
        .i_rx_byte     (i_in.rx_byte),
        .i_frame_start (i_in.frame_start),
        .o_frame       (w_frame)
    );

    htfd_scale u_scale (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (w_frame.last),
        .i_raw_t      (w_frame.raw_t),
        .i_raw_h      (w_frame.raw_h),
        .o_temp_code  (w_temp_code),
        .o_humid_code (w_humid_code),
        .o_done       (w_scale_done)
    );

    htfd_avg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (r_state == S_LOAD),
        .i_sum_t (w_sum_t),
        .i_sum_h (w_sum_h),
        .i_cnt   (r_fill),
        .o_avg_t (w_avg_t),
        .o_avg_h (w_avg_h),
        .o_done  (w_div_done)
    );

    // scaled code is below 20000, so the offset wraps correctly into 15 bits
    assign w_tval = signed'(TVAL_W'(w_temp_code - TVAL_W'(TEMP_OFFSET)));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_frame.last) n_state = S_SCALE;
            S_SCALE: if (w_scale_done) n_state = S_LOAD;
            S_LOAD:  n_state = S_DIV;
            S_DIV:   if (w_div_done)   n_state = S_OUT;
            S_OUT:   if (w_out_free)   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // window: oldest entry at index 0, newest pushed at the top
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW_DEPTH; i++) begin
                r_twin[i] <= '0;
                r_hwin[i] <= '0;
            end
            r_fill <= '0;
        end else if (w_scale_done) begin
            for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
                r_twin[i] <= r_twin[i+1];
                r_hwin[i] <= r_hwin[i+1];
            end
            r_twin[WINDOW_DEPTH-1] <= w_tval;
            r_hwin[WINDOW_DEPTH-1] <= w_humid_code;
            if (r_fill < FILL_W'(WINDOW_DEPTH)) begin
                r_fill <= r_fill + 1'b1;
            end
        end
    end

    always_comb begin
        w_sum_t = '0;
        w_sum_h = '0;
        for (int i = 0; i < WINDOW_DEPTH; i++) begin
            w_sum_t = w_sum_t + TSUM_W'(r_twin[i]);
            w_sum_h = w_sum_h + HSUM_W'(r_hwin[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_temp    <= w_avg_t;
            r_out_humid   <= w_avg_h;
            r_out_samples <= 2'(r_fill);
            r_out_raw_t   <= w_frame.raw_t;
            r_out_raw_h   <= w_frame.raw_h;
            r_out_status  <= w_frame.status;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.temperature_avg   = r_out_temp;
    assign o_out.humidity_avg      = r_out_humid;
    assign o_out.samples_in_window = r_out_samples;
    assign o_out.raw_temp_code     = r_out_raw_t;
    assign o_out.raw_humid_code    = r_out_raw_h;
    assign o_out.sensor_status     = r_out_status;

    a_scale_done_in_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_scale_done |-> r_state == S_SCALE)
        else $error("scaler finished outside the scaling phase");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == S_DIV)
        else $error("divider finished outside the division phase");

    a_divisor_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_LOAD |-> r_fill != '0 && r_fill <= FILL_W'(WINDOW_DEPTH))
        else $error("divider loaded with an invalid fill count");

    a_last_starts_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_frame.last |=> r_state == S_SCALE)
        else $error("seventh byte did not start scaling");

endmodule
